// File: sv/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;
   localparam int SIG_BYTES     = 16;

   // Register indexes, taken from paddr[5:3].
   localparam logic [2:0] REG_PATTERN_LOW      = 3'd0;
   localparam logic [2:0] REG_PATTERN_HIGH     = 3'd1;
   localparam logic [2:0] REG_CARE_MASK        = 3'd2;
   localparam logic [2:0] REG_PATTERN_LENGTH   = 3'd3;
   localparam logic [2:0] REG_OCCURRENCE_INDEX = 3'd4;
   localparam logic [2:0] REG_BASE_ADDRESS     = 3'd5;

   typedef struct packed {
      logic [8*SIG_BYTES-1:0] pattern;
      logic [SIG_BYTES-1:0]   care_mask;
      logic [4:0]             pattern_length;
      logic [15:0]            occurrence_index;
      logic [63:0]            base_address;
   } mbps_cfg_type;

   typedef struct packed {
      logic step;   // a word is processed this cycle
      logic shift;  // the word enters the window
      logic clear;  // end of region: window empties
   } mbps_win_ctl_type;

endpackage

// File: sv/masked_byte_pattern_scan.sv
// Masked byte pattern scanner: top level with input and result registers and match counting.
//
// The block takes one memory byte per word and can accept a word in every cycle while
// results are taken; each word passes an input register and then a result register,
// where its result is presented. The whole window of up to PATTERN_BYTES bytes is
// compared with the masked signature combinationally between those two registers,
// and the result register frees its slot as soon as the result is taken, so the
// rate is one word a cycle whenever the result side is ready. A word gives at
// most one result: found with the start address when the requested occurrence completes,
// or not-found with address zero on the last byte of a region that held no such match.
// Bytes after a report are dropped until the last byte, which restarts the scan.
// There is no clearing pass after reset.
module masked_byte_pattern_scan #(
   parameter int PATTERN_BYTES = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [63:0]                         rsp_match_address,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mbps_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mbps_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import mbps_pkg::*;

   localparam logic [4:0] MAX_LEN = 5'(PATTERN_BYTES);

   mbps_cfg_type          cfg;
   mbps_win_ctl_type      win_ctl;
   logic [4:0]            active_len;
   logic                  hit;

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_data_ff, s1_data_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  s1_go;

   logic [POSITION_BITS-1:0] byte_position_ff, byte_position_in;
   logic [15:0]           match_count_ff, match_count_in;
   logic                  reported_ff, reported_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic [63:0]           address_ff, address_in;

   logic                  emit_found;
   logic                  emit;
   logic [POSITION_BITS-1:0] start_pos;

   assign csr_pready = 1'b1;

   mbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   always_comb begin
      priority if (cfg.pattern_length == 5'd0) begin
         active_len = 5'd1;
      end else if (cfg.pattern_length > MAX_LEN) begin
         active_len = MAX_LEN;
      end else begin
         active_len = cfg.pattern_length;
      end
   end

   // The input register moves on whenever the result register has room.
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   assign win_ctl.step  = s1_go;
   assign win_ctl.shift = !reported_ff;
   assign win_ctl.clear = s1_last_ff;

   mbps_window #(
      .PATTERN_BYTES (PATTERN_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctl        (win_ctl),
      .data_byte  (s1_data_ff),
      .active_len (active_len),
      .cfg        (cfg),
      .hit        (hit)
   );

   assign emit_found = !reported_ff && hit && (match_count_ff == cfg.occurrence_index);
   assign emit       = !reported_ff && (emit_found || s1_last_ff);
   assign start_pos  = byte_position_ff - POSITION_BITS'(active_len - 5'd1);

   always_comb begin
      s1_valid_in      = s1_valid_ff;
      s1_data_in       = s1_data_ff;
      s1_last_in       = s1_last_ff;
      byte_position_in = byte_position_ff;
      match_count_in   = match_count_ff;
      reported_in      = reported_ff;
      rsp_valid_in     = rsp_valid_ff;
      found_in         = found_ff;
      address_in       = address_ff;

      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_go) begin
         rsp_valid_in = emit;
         found_in     = emit_found;
         address_in   = emit_found ? cfg.base_address + 64'(start_pos) : 64'd0;
         if (!reported_ff) begin
            byte_position_in = byte_position_ff + POSITION_BITS'(1);
            if (hit && !emit_found) begin
               match_count_in = match_count_ff + 16'd1;
            end
            if (emit_found) begin
               reported_in = 1'b1;
            end
         end
         // The last byte of a region restarts every count.
         if (s1_last_ff) begin
            byte_position_in = '0;
            match_count_in   = '0;
            reported_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         byte_position_ff <= '0;
         match_count_ff   <= '0;
         reported_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         byte_position_ff <= byte_position_in;
         match_count_ff   <= match_count_in;
         reported_ff      <= reported_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_last_ff <= s1_last_in;
      found_ff   <= found_in;
      address_ff <= address_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_address = address_ff;

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> address_ff == 64'd0)
      else $error("not-found result carries a non-zero address");

   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=>
         !reported_ff && byte_position_ff == '0 && match_count_ff == '0)
      else $error("scan state not restarted after the last byte");

   a_found_sets_reported: assert property (@(posedge clock) disable iff (reset)
      s1_go && emit_found && !s1_last_ff |=> reported_ff)
      else $error("report flag not set after a found result");

   a_no_result_after_report: assert property (@(posedge clock) disable iff (reset)
      s1_go && reported_ff |=> !rsp_valid_ff)
      else $error("result emitted after the occurrence was reported");

endmodule

// File: sv/mbps_csr.sv
// Configuration register file with an APB-style access port.
module mbps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mbps_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [mbps_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [mbps_pkg::CSR_DATA_BITS-1:0]  prdata,
   output mbps_pkg::mbps_cfg_type              cfg
);
   import mbps_pkg::*;

   logic [63:0] pattern_low_ff, pattern_low_in;
   logic [63:0] pattern_high_ff, pattern_high_in;
   logic [15:0] care_mask_ff, care_mask_in;
   logic [4:0]  pattern_length_ff, pattern_length_in;
   logic [15:0] occurrence_index_ff, occurrence_index_in;
   logic [63:0] base_address_ff, base_address_in;
   logic        write_en;
   logic [2:0]  reg_index;

   assign write_en  = psel & penable & pwrite;
   assign reg_index = paddr[5:3];

   always_comb begin
      pattern_low_in      = pattern_low_ff;
      pattern_high_in     = pattern_high_ff;
      care_mask_in        = care_mask_ff;
      pattern_length_in   = pattern_length_ff;
      occurrence_index_in = occurrence_index_ff;
      base_address_in     = base_address_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_PATTERN_LOW:      pattern_low_in      = pwdata;
            REG_PATTERN_HIGH:     pattern_high_in     = pwdata;
            REG_CARE_MASK:        care_mask_in        = pwdata[15:0];
            REG_PATTERN_LENGTH:   pattern_length_in   = pwdata[4:0];
            REG_OCCURRENCE_INDEX: occurrence_index_in = pwdata[15:0];
            REG_BASE_ADDRESS:     base_address_in     = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff      <= '0;
         pattern_high_ff     <= '0;
         care_mask_ff        <= '0;
         pattern_length_ff   <= 5'd1;
         occurrence_index_ff <= '0;
         base_address_ff     <= '0;
      end else begin
         pattern_low_ff      <= pattern_low_in;
         pattern_high_ff     <= pattern_high_in;
         care_mask_ff        <= care_mask_in;
         pattern_length_ff   <= pattern_length_in;
         occurrence_index_ff <= occurrence_index_in;
         base_address_ff     <= base_address_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LOW:      prdata = pattern_low_ff;
         REG_PATTERN_HIGH:     prdata = pattern_high_ff;
         REG_CARE_MASK:        prdata = {48'd0, care_mask_ff};
         REG_PATTERN_LENGTH:   prdata = {59'd0, pattern_length_ff};
         REG_OCCURRENCE_INDEX: prdata = {48'd0, occurrence_index_ff};
         REG_BASE_ADDRESS:     prdata = base_address_ff;
         default:              prdata = '0;
      endcase
   end

   assign cfg.pattern          = {pattern_high_ff, pattern_low_ff};
   assign cfg.care_mask        = care_mask_ff;
   assign cfg.pattern_length   = pattern_length_ff;
   assign cfg.occurrence_index = occurrence_index_ff;
   assign cfg.base_address     = base_address_ff;

endmodule

// File: sv/mbps_window.sv
// Sliding byte window with its fill count and the parallel masked compare.
module mbps_window #(
   parameter int PATTERN_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mbps_pkg::mbps_win_ctl_type      ctl,
   input  logic [7:0]                      data_byte,
   input  logic [4:0]                      active_len,
   input  mbps_pkg::mbps_cfg_type          cfg,
   output logic                            hit
);
   import mbps_pkg::*;

   localparam int FILL_BITS = $clog2(PATTERN_BYTES + 1);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(PATTERN_BYTES);

   logic [7:0]           win_ff [PATTERN_BYTES];
   logic [7:0]           win_in [PATTERN_BYTES];
   logic [7:0]           next_win [PATTERN_BYTES];
   logic [FILL_BITS-1:0] fill_ff, fill_in, next_fill;
   logic [7:0]           sel_byte;
   logic                 all_equal;

   // The window after this word has entered it, newest byte at index 0.
   always_comb begin
      next_win[0] = data_byte;
      for (int i = 1; i < PATTERN_BYTES; i++) begin
         next_win[i] = win_ff[i-1];
      end
      next_fill = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + FILL_BITS'(1);
   end

   // Signature byte k lines up with the window byte that arrived len-1-k words ago.
   always_comb begin
      all_equal = 1'b1;
      sel_byte  = 8'd0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         sel_byte = 8'd0;
         for (int j = 0; j < PATTERN_BYTES; j++) begin
            if (5'(j) == active_len - 5'd1 - 5'(k)) begin
               sel_byte = next_win[j];
            end
         end
         if (5'(k) < active_len && cfg.care_mask[k] &&
             sel_byte != cfg.pattern[8*k +: 8]) begin
            all_equal = 1'b0;
         end
      end
      hit = all_equal && (5'(next_fill) >= active_len);
   end

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (ctl.step) begin
         if (ctl.shift) begin
            win_in  = next_win;
            fill_in = next_fill;
         end
         if (ctl.clear) begin
            fill_in = '0;
         end
      end
   end

   // Window bytes beyond the fill count never decide a hit, so they need no reset.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// File: tb/tb_masked_byte_pattern_scan.sv
// Self-checking testbench for the masked byte pattern scanner: directed table, then random regions.
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;
   import mbps_pkg::*;

   typedef enum bit [1:0] {EXP_MODEL, EXP_NONE, EXP_HIT, EXP_MISS} exp_kind_type;
   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   reg_idx;
      bit [63:0]    value;    // register value, or expected address of a word row
      bit [7:0]     data;
      bit           last;
      exp_kind_type chk;
   } plan_row_type;

   typedef struct packed {
      bit        valid;
      bit        found;
      bit [63:0] addr;
   } scan_out_type;

   localparam int PLAN_ROWS    = 34;
   localparam int RANDOM_WORDS = 650;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'h00;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_found;
   logic [63:0]              rsp_match_address;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Register mirror and scan state of the predictor.
   bit [63:0] cfg_pat_lo, cfg_pat_hi, cfg_base;
   bit [15:0] cfg_care, cfg_occ;
   bit [4:0]  cfg_len;
   bit [7:0]  win [16];
   bit [31:0] pos;
   bit [15:0] hits;
   bit        scan_done;
   int        fill;

   scan_out_type pending_reports [$];
   scan_out_type oldest;
   plan_row_type plan [PLAN_ROWS];
   int           errors = 0;
   int           live_words = 0;
   bit           calm = 1'b0;

   masked_byte_pattern_scan dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_len();
      if (cfg_len == 0) return 1;
      if (cfg_len > 16) return 16;
      return int'(cfg_len);
   endfunction

   function automatic void restart_scan();
      foreach (win[i]) win[i] = 8'h00;
      pos       = '0;
      hits      = '0;
      scan_done = 1'b0;
      fill      = 0;
   endfunction

   // Advances the scan by one byte and returns the report it causes, if any.
   function automatic scan_out_type scan_predict(bit [7:0] d, bit l);
      scan_out_type r;
      int           len;
      bit           hit;
      bit [31:0]    start;
      bit [127:0]   sig;
      r = '0;
      if (!scan_done) begin
         len = active_len();
         for (int i = 15; i > 0; i--) win[i] = win[i-1];
         win[0] = d;
         if (fill < 16) fill++;
         sig = {cfg_pat_hi, cfg_pat_lo};
         hit = (fill >= len);
         for (int k = 0; k < len; k++)
            if (cfg_care[k] && win[len-1-k] != sig[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            if (hits == cfg_occ) begin
               start     = pos - 32'(len - 1);
               r.valid   = 1'b1;
               r.found   = 1'b1;
               r.addr    = cfg_base + {32'h0, start};
               scan_done = 1'b1;
            end else begin
               hits++;
            end
         end
         if (l && !r.valid) begin
            r.valid = 1'b1;
            r.found = 1'b0;
            r.addr  = '0;
         end
         pos++;
      end
      if (l) restart_scan();
      return r;
   endfunction

   task automatic set_reg(logic [2:0] idx, bit [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PATTERN_LOW:      cfg_pat_lo = val;
         REG_PATTERN_HIGH:     cfg_pat_hi = val;
         REG_CARE_MASK:        cfg_care   = val[15:0];
         REG_PATTERN_LENGTH:   cfg_len    = val[4:0];
         REG_OCCURRENCE_INDEX: cfg_occ    = val[15:0];
         REG_BASE_ADDRESS:     cfg_base   = val;
         default: ;
      endcase
   endtask

   // Holds the sender back until every report is in and trailing words have drained.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_word(bit [7:0] d, bit l, exp_kind_type chk, bit [63:0] addr);
      scan_out_type p;
      if (!calm)
         while ($urandom_range(99) < 8) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      do @(posedge clock); while (!req_ready);
      live_words++;
      calm = (live_words >= 250 && live_words < 400);
      p = scan_predict(d, l);
      case (chk)
         EXP_MODEL: if (p.valid) pending_reports.push_back(p);
         EXP_HIT:   pending_reports.push_back(scan_out_type'{1'b1, 1'b1, addr});
         EXP_MISS:  pending_reports.push_back(scan_out_type'{1'b1, 1'b0, 64'h0});
         default: ;
      endcase
   endtask

   // One region of n bytes; the signature is planted now and then, wildcards filled at random.
   task automatic random_region(int n, bit close);
      bit [127:0] sig;
      bit [7:0]   b;
      bit         planting;
      int         k, eff, sel;
      sig      = {cfg_pat_hi, cfg_pat_lo};
      eff      = active_len();
      planting = 1'b0;
      k        = 0;
      for (int i = 0; i < n; i++) begin
         if (!planting && $urandom_range(99) < 12) begin
            planting = 1'b1;
            k        = 0;
         end
         if (planting) begin
            b = cfg_care[k] ? sig[8*k +: 8] : 8'($urandom);
            k++;
            if (k >= eff) planting = 1'b0;
         end else if ($urandom_range(1) == 1) begin
            sel = $urandom_range(eff - 1, 0);
            b   = sig[8*sel +: 8];
         end else begin
            b = 8'($urandom);
         end
         push_word(b, close && (i == n - 1), EXP_MODEL, 64'h0);
      end
   endtask

   task automatic random_phase();
      bit [63:0] lo_w, hi_w, base_w;
      bit [15:0] care_w, occ_w;
      bit [4:0]  len_w;
      int        pick, rlen;
      pick  = $urandom_range(99);
      len_w = (pick < 60) ? 5'($urandom_range(8, 1)) :
              (pick < 85) ? 5'($urandom_range(16, 9)) :
              (pick < 90) ? 5'd0 : 5'($urandom_range(31, 17));
      pick   = $urandom_range(99);
      care_w = (pick < 25) ? 16'hFFFF : (pick < 50) ? 16'($urandom) :
               (pick < 75) ? 16'($urandom & $urandom) : (pick < 85) ? 16'h0 : 16'($urandom);
      pick = $urandom_range(99);
      lo_w = (pick < 5) ? '1 : (pick < 10) ? '0 : {$urandom, $urandom};
      pick = $urandom_range(99);
      hi_w = (pick < 5) ? '1 : (pick < 10) ? '0 : {$urandom, $urandom};
      pick  = $urandom_range(99);
      occ_w = (pick < 55) ? 16'd0 : (pick < 90) ? 16'($urandom_range(3, 1)) :
              (pick < 95) ? 16'hFFFF : 16'($urandom);
      pick   = $urandom_range(99);
      base_w = (pick < 10) ? '0 : (pick < 20) ? '1 : {$urandom, $urandom};
      settle();
      set_reg(REG_PATTERN_LOW, lo_w);
      set_reg(REG_PATTERN_HIGH, hi_w);
      set_reg(REG_CARE_MASK, {48'h0, care_w});
      set_reg(REG_PATTERN_LENGTH, {59'h0, len_w});
      set_reg(REG_OCCURRENCE_INDEX, {48'h0, occ_w});
      set_reg(REG_BASE_ADDRESS, base_w);
      repeat ($urandom_range(5, 2)) begin
         rlen = ($urandom_range(99) < 80) ? $urandom_range(24, 1) : $urandom_range(60, 25);
         random_region(rlen, 1'b1);
      end
      // Now and then the phase stops inside a region, so new settings apply mid-region.
      if ($urandom_range(99) < 15) random_region($urandom_range(5, 1), 1'b0);
   endtask

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= 8);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report: expected none, got found=%0d address=%h",
                     $time, rsp_found, rsp_match_address);
            errors++;
         end else begin
            oldest = pending_reports.pop_front();
            if (rsp_found !== oldest.found || rsp_match_address !== oldest.addr) begin
               $display({"%0t: report mismatch: expected found=%0d address=%h, ",
                         "got found=%0d address=%h"},
                        $time, oldest.found, oldest.addr, rsp_found, rsp_match_address);
               errors++;
            end
         end
      end
   end

   initial begin
      int guard;
      plan = '{
         '{ROW_WORD, 3'd0, 64'h0, 8'h00, 1'b0, EXP_HIT},
         '{ROW_WORD, 3'd0, 64'h0, 8'hFF, 1'b1, EXP_NONE},
         '{ROW_WORD, 3'd0, 64'h0, 8'hA5, 1'b1, EXP_HIT},
         '{ROW_CSR, REG_PATTERN_LOW, 64'h0123_4567_89AB_CD5A, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_CARE_MASK, 64'hFFFF, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_OCCURRENCE_INDEX, 64'h1, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, EXP_NONE},
         '{ROW_WORD, 3'd0, 64'h0, 8'h5A, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h00, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h1, 8'h5A, 1'b0, EXP_HIT},
         '{ROW_WORD, 3'd0, 64'h0, 8'h5A, 1'b1, EXP_NONE},
         '{ROW_WORD, 3'd0, 64'h0, 8'h11, 1'b1, EXP_MISS},
         '{ROW_CSR, REG_PATTERN_LOW, 64'h0706_0504_0302_0100, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_OCCURRENCE_INDEX, 64'h0, 8'h00, 1'b0, EXP_NONE},
         '{ROW_CSR, REG_BASE_ADDRESS, 64'h1000, 8'h00, 1'b0, EXP_NONE},
         '{ROW_WORD, 3'd0, 64'h0, 8'h00, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h01, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h02, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h03, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h04, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h05, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h06, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h07, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h08, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h09, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h0A, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h0B, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h0C, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h0D, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h0, 8'h0E, 1'b0, EXP_MODEL},
         '{ROW_WORD, 3'd0, 64'h1000, 8'h0F, 1'b1, EXP_HIT}
      };
      cfg_pat_lo = '0;
      cfg_pat_hi = '0;
      cfg_care   = '0;
      cfg_len    = 5'd1;
      cfg_occ    = '0;
      cfg_base   = '0;
      restart_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            set_reg(plan[i].reg_idx, plan[i].value);
         end else begin
            push_word(plan[i].data, plan[i].last, plan[i].chk, plan[i].value);
         end
      end

      live_words = 0;
      while (live_words < RANDOM_WORDS) random_phase();

      req_valid <= 1'b0;
      guard = 0;
      while (pending_reports.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d reports never arrived, oldest expected found=%0d address=%h",
                  $time, pending_reports.size(), pending_reports[0].found,
                  pending_reports[0].addr);
         errors++;
      end
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: masked_byte_pattern_scan.f
sv/mbps_pkg.sv
sv/mbps_csr.sv
sv/mbps_window.sv
sv/masked_byte_pattern_scan.sv
tb/tb_masked_byte_pattern_scan.sv
